/* rtl/core/mesh_edge_sharpness_classifier_defines.svh */
// Assertion macros shared by the edge classifier RTL.
// Include by bare file name; no other dependencies.
`ifndef MESH_EDGE_SHARPNESS_CLASSIFIER_DEFINES_SVH
`define MESH_EDGE_SHARPNESS_CLASSIFIER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MESC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MESC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mesc_pkg.sv */
// Package for the edge classifier: widths, codes and control types.
// No dependencies.
`default_nettype none

package mesc_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int NORM_BITS      = 16;
    localparam int PROD_BITS      = 2 * NORM_BITS;
    localparam int MAG_BITS       = PROD_BITS - 1;
    localparam int SQ_BITS        = 2 * MAG_BITS;
    localparam int SQSUM_BITS     = SQ_BITS + 2;
    localparam int THR_BITS       = 29;
    localparam int THR_SHIFT      = 28;
    localparam int CFG_IDX_BITS   = 2;
    localparam int KIND_BITS      = 2;
    localparam int N_STAGES       = 5;

    localparam logic [THR_BITS-1:0] SHARP_RESET = THR_BITS'(134217728);
    localparam logic [THR_BITS-1:0] PLANE_RESET = THR_BITS'(8);

    typedef enum logic [KIND_BITS-1:0] {
        KIND_SHARP      = 2'd0,
        KIND_NEVER      = 2'd1,
        KIND_SOFT_OUTER = 2'd2
    } t_edge_kind;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SHARP = 2'd0,
        CFG_PLANE = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic s0;
        logic s1;
        logic s2;
        logic s3;
    } t_cross_en;

endpackage

`default_nettype wire

/* rtl/core/mesc_if.sv */
// Stream interfaces of the edge classifier: edge beat in, kind beat out.
// Depends on mesc_pkg.
`default_nettype none

interface mesc_edge_if #(
    parameter int COORD_BITS = mesc_pkg::COORD_BITS_DEF
);
    import mesc_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [NORM_BITS-1:0]  norm_a_x;
    logic signed [NORM_BITS-1:0]  norm_a_y;
    logic signed [NORM_BITS-1:0]  norm_a_z;
    logic signed [NORM_BITS-1:0]  norm_b_x;
    logic signed [NORM_BITS-1:0]  norm_b_y;
    logic signed [NORM_BITS-1:0]  norm_b_z;
    logic signed [COORD_BITS-1:0] far_vert_x;
    logic signed [COORD_BITS-1:0] far_vert_y;
    logic signed [COORD_BITS-1:0] far_vert_z;
    logic signed [COORD_BITS-1:0] edge_vert_x;
    logic signed [COORD_BITS-1:0] edge_vert_y;
    logic signed [COORD_BITS-1:0] edge_vert_z;

    modport source (
        output valid, norm_a_x, norm_a_y, norm_a_z, norm_b_x, norm_b_y, norm_b_z,
        output far_vert_x, far_vert_y, far_vert_z, edge_vert_x, edge_vert_y, edge_vert_z,
        input  ready
    );

    modport sink (
        input  valid, norm_a_x, norm_a_y, norm_a_z, norm_b_x, norm_b_y, norm_b_z,
        input  far_vert_x, far_vert_y, far_vert_z, edge_vert_x, edge_vert_y, edge_vert_z,
        output ready
    );
endinterface

interface mesc_kind_if;
    import mesc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_BITS-1:0] edge_kind;

    modport source (output valid, edge_kind, input ready);
    modport sink   (input valid, edge_kind, output ready);
endinterface

`default_nettype wire

/* rtl/core/mesc_cross_sq.sv */
// Four-stage squared length of the cross product of two face normals.
// Depends on mesc_pkg; stage enables come from the top-level valid chain.
`default_nettype none

module mesc_cross_sq (
    input  wire logic                                i_clk,
    input  wire mesc_pkg::t_cross_en                 i_en,
    input  wire logic signed [mesc_pkg::NORM_BITS-1:0] i_ax,
    input  wire logic signed [mesc_pkg::NORM_BITS-1:0] i_ay,
    input  wire logic signed [mesc_pkg::NORM_BITS-1:0] i_az,
    input  wire logic signed [mesc_pkg::NORM_BITS-1:0] i_bx,
    input  wire logic signed [mesc_pkg::NORM_BITS-1:0] i_by,
    input  wire logic signed [mesc_pkg::NORM_BITS-1:0] i_bz,
    output logic [mesc_pkg::SQSUM_BITS-1:0]          o_cross_sq
);
    import mesc_pkg::*;

    logic signed [PROD_BITS-1:0] r_p_aybz, r_p_azby, r_p_azbx, r_p_axbz, r_p_axby, r_p_aybx;
    logic signed [PROD_BITS-1:0] n_cx, n_cy, n_cz;
    logic [MAG_BITS-1:0]         r_mag_x, r_mag_y, r_mag_z;
    logic [SQ_BITS-1:0]          r_sq_x, r_sq_y, r_sq_z;
    logic [SQSUM_BITS-1:0]       r_sum;

    function automatic logic [MAG_BITS-1:0] f_mag(input logic signed [PROD_BITS-1:0] v);
        logic signed [PROD_BITS-1:0] a;
        a = v[PROD_BITS-1] ? -v : v;
        return a[MAG_BITS-1:0];
    endfunction

    always_comb begin
        n_cx = r_p_aybz - r_p_azby;
        n_cy = r_p_azbx - r_p_axbz;
        n_cz = r_p_axby - r_p_aybx;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s0) begin
            r_p_aybz <= i_ay * i_bz;
            r_p_azby <= i_az * i_by;
            r_p_azbx <= i_az * i_bx;
            r_p_axbz <= i_ax * i_bz;
            r_p_axby <= i_ax * i_by;
            r_p_aybx <= i_ay * i_bx;
        end
        if (i_en.s1) begin
            r_mag_x <= f_mag(n_cx);
            r_mag_y <= f_mag(n_cy);
            r_mag_z <= f_mag(n_cz);
        end
        if (i_en.s2) begin
            r_sq_x <= r_mag_x * r_mag_x;
            r_sq_y <= r_mag_y * r_mag_y;
            r_sq_z <= r_mag_z * r_mag_z;
        end
        if (i_en.s3) begin
            r_sum <= SQSUM_BITS'(r_sq_x) + SQSUM_BITS'(r_sq_y) + SQSUM_BITS'(r_sq_z);
        end
    end

    assign o_cross_sq = r_sum;

endmodule

`default_nettype wire

/* rtl/core/mesh_edge_sharpness_classifier.sv */
// An accepted edge beat passes the five pipeline registers to its kind beat on o_kind.
// Throughput: one edge per cycle while o_kind is not stalled; the per-stage ready chain
// fills bubbles and holds a full stage only while every later stage is full and o_kind is stalled.
// Reset (synchronous, active low) clears all stage valid bits and loads
// sharp_sine_sq = 2^27, plane_sine_sq = 8.
// Depends on mesc_pkg, mesc_if and mesc_cross_sq.
`default_nettype none

`include "mesh_edge_sharpness_classifier_defines.svh"

module mesh_edge_sharpness_classifier #(
    parameter int COORD_BITS = mesc_pkg::COORD_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    mesc_edge_if.sink                                i_edge,
    mesc_kind_if.source                              o_kind,
    input  wire logic                                i_cfg_we,
    input  wire logic [mesc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [mesc_pkg::THR_BITS-1:0]       i_cfg_data
);
    import mesc_pkg::*;

    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int NDIF_BITS  = NORM_BITS + 1;
    localparam int DPROD_BITS = DIFF_BITS + NDIF_BITS;
    localparam int DSUM_BITS  = DPROD_BITS + 2;
    localparam int PAD_BITS   = SQSUM_BITS - THR_BITS - THR_SHIFT;
    localparam int LAST       = N_STAGES - 1;

    logic [THR_BITS-1:0] r_sharp, r_plane;
    logic [N_STAGES-1:0] r_v, v_in, rdy, en;

    logic signed [DIFF_BITS-1:0]  r_dv_x, r_dv_y, r_dv_z;
    logic signed [NDIF_BITS-1:0]  r_dn_x, r_dn_y, r_dn_z;
    logic signed [DPROD_BITS-1:0] r_dp_x, r_dp_y, r_dp_z;
    logic signed [DSUM_BITS-1:0]  r_dot;
    logic                         r_dot_pos;
    logic [SQSUM_BITS-1:0]        cross_sq, sharp_thr, plane_thr;
    t_cross_en                    cross_en;
    t_edge_kind                   r_kind, n_kind;

    // ready chain, back to front
    always_comb begin
        v_in = {r_v[LAST-1:0], i_edge.valid};
        rdy[LAST] = !r_v[LAST] || o_kind.ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
        en = rdy & v_in;
    end

    assign i_edge.ready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_sharp <= SHARP_RESET;
            r_plane <= PLANE_RESET;
        end else begin
            for (int k = 0; k < N_STAGES; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= v_in[k];
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SHARP: r_sharp <= i_cfg_data;
                    CFG_PLANE: r_plane <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign cross_en = '{s0: en[0], s1: en[1], s2: en[2], s3: en[3]};

    mesc_cross_sq u_cross (
        .i_clk      (i_clk),
        .i_en       (cross_en),
        .i_ax       (i_edge.norm_a_x),
        .i_ay       (i_edge.norm_a_y),
        .i_az       (i_edge.norm_a_z),
        .i_bx       (i_edge.norm_b_x),
        .i_by       (i_edge.norm_b_y),
        .i_bz       (i_edge.norm_b_z),
        .o_cross_sq (cross_sq)
    );

    // dot product (edge - far) . (norm_b - norm_a)
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_dv_x <= $signed({i_edge.edge_vert_x[COORD_BITS-1], i_edge.edge_vert_x})
                    - $signed({i_edge.far_vert_x[COORD_BITS-1], i_edge.far_vert_x});
            r_dv_y <= $signed({i_edge.edge_vert_y[COORD_BITS-1], i_edge.edge_vert_y})
                    - $signed({i_edge.far_vert_y[COORD_BITS-1], i_edge.far_vert_y});
            r_dv_z <= $signed({i_edge.edge_vert_z[COORD_BITS-1], i_edge.edge_vert_z})
                    - $signed({i_edge.far_vert_z[COORD_BITS-1], i_edge.far_vert_z});
            r_dn_x <= $signed({i_edge.norm_b_x[NORM_BITS-1], i_edge.norm_b_x})
                    - $signed({i_edge.norm_a_x[NORM_BITS-1], i_edge.norm_a_x});
            r_dn_y <= $signed({i_edge.norm_b_y[NORM_BITS-1], i_edge.norm_b_y})
                    - $signed({i_edge.norm_a_y[NORM_BITS-1], i_edge.norm_a_y});
            r_dn_z <= $signed({i_edge.norm_b_z[NORM_BITS-1], i_edge.norm_b_z})
                    - $signed({i_edge.norm_a_z[NORM_BITS-1], i_edge.norm_a_z});
        end
        if (en[1]) begin
            r_dp_x <= r_dv_x * r_dn_x;
            r_dp_y <= r_dv_y * r_dn_y;
            r_dp_z <= r_dv_z * r_dn_z;
        end
        if (en[2]) begin
            r_dot <= $signed({{2{r_dp_x[DPROD_BITS-1]}}, r_dp_x})
                   + $signed({{2{r_dp_y[DPROD_BITS-1]}}, r_dp_y})
                   + $signed({{2{r_dp_z[DPROD_BITS-1]}}, r_dp_z});
        end
        if (en[3]) begin
            r_dot_pos <= !r_dot[DSUM_BITS-1] && (r_dot != '0);
        end
        if (en[LAST]) begin
            r_kind <= n_kind;
        end
    end

    assign sharp_thr = {{PAD_BITS{1'b0}}, r_sharp, {THR_SHIFT{1'b0}}};
    assign plane_thr = {{PAD_BITS{1'b0}}, r_plane, {THR_SHIFT{1'b0}}};

    always_comb begin
        if (cross_sq > sharp_thr) begin
            n_kind = KIND_SHARP;
        end else if (cross_sq < plane_thr) begin
            n_kind = KIND_NEVER;
        end else if (r_dot_pos) begin
            n_kind = KIND_SOFT_OUTER;
        end else begin
            n_kind = KIND_NEVER;
        end
    end

    assign o_kind.valid     = r_v[LAST];
    assign o_kind.edge_kind = r_kind;

    `MESC_ASSERT_NXT(a_enter, i_clk, i_rst_n, i_edge.valid && i_edge.ready, r_v[0], "beat lost at entry")
    `MESC_ASSERT_IMP(a_full, i_clk, i_rst_n, !i_edge.ready, &r_v, "ready low with a bubble in the pipe")
    `MESC_ASSERT_NXT(a_drain, i_clk, i_rst_n, r_v[LAST-1] && o_kind.ready, r_v[LAST], "beat lost at output")
    `MESC_ASSERT_NXT(a_cfg, i_clk, i_rst_n, i_cfg_we && (i_cfg_idx == CFG_SHARP), r_sharp == $past(i_cfg_data), "sharp threshold not written")

endmodule

`default_nettype wire
